// ===== design/sha1_stream_hasher_top_defines.svh =====
// Assertion macros for the SHA-1 stream hasher RTL (used by sha1sh_ctrl).
// Expects signals clk and rst_n in the including module's scope.
`ifndef SHA1_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset
`define SHA1SH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define SHA1SH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sha1sh_pkg.sv =====
// Types and constants for the SHA-1 stream hasher.
// Shared by the controller, the datapath and the top level; no dependencies.
package sha1sh_pkg;

  localparam logic [5:0] FILL_LEN_POS  = 6'd56;  // length field starts here
  localparam logic [5:0] FILL_LAST_POS = 6'd63;
  localparam logic [6:0] LAST_RND      = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR0 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR1 = 32'hCA62C1D6;

  // H0 in the top bits
  localparam logic [159:0] INIT_CHAIN = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};

  typedef enum logic [1:0] {
    BSEL_DATA  = 2'd0,
    BSEL_PAD80 = 2'd1,
    BSEL_ZERO  = 2'd2,
    BSEL_LEN   = 2'd3
  } bsel_t;

  typedef enum logic [1:0] {
    PH_CH   = 2'd0,
    PH_PAR0 = 2'd1,
    PH_MAJ  = 2'd2,
    PH_PAR1 = 2'd3
  } phase_t;

  typedef struct packed {
    logic       push;         // shift one byte into the block buffer
    bsel_t      bsel;
    logic       capture_len;  // latch bit count at finish
    logic       load_work;    // a..e <= chain
    logic       round_en;
    phase_t     phase;
    logic       final_add;    // chain += a..e
    logic       clear_msg;    // back to initial chain, zero count
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill_pos;
  } sts_t;

endpackage

// ===== design/sha1_stream_hasher_top.sv =====
// SHA-1 stream hasher top level: wires the controller to the datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_dp.
//
//  channel | dir | tdata                                  | tuser      | tlast
//  in_     | in  | [7:0] data_byte                        | kind       | -
//  out_    | out | [31:0] digest_word, [34:32] word_index | -          | last_word
//
// A data byte is pushed into the block buffer; the byte that fills a block starts a
// compression (80 rounds of the single round unit, then the chain update).
// A finish is accepted, then the padding bytes (9 to 72) are pushed in turn and each
// filled block (one or two) is compressed, then five output transfers follow. Input is held
// off from the finish until the fifth digest word is taken; out_tready low
// stalls only the output.
// Reset is synchronous, active low, and restores the initial chain and count.
module sha1_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast
);

  sha1sh_pkg::cmd_t cmd;
  sha1sh_pkg::sts_t sts;
  logic [31:0]      digest_word;
  logic [2:0]       word_index;

  sha1sh_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_kind        (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_word_index (word_index),
    .out_last       (out_tlast),
    .sts            (sts),
    .cmd            (cmd)
  );

  sha1sh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .sts         (sts),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b00000, word_index, digest_word};

endmodule

// ===== design/sha1sh_dp.sv =====
// SHA-1 datapath: block/schedule shift register, working vars, chain, bit count.
// Driven by sha1sh_ctrl via sha1sh_pkg::cmd_t.
module sha1sh_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1sh_pkg::cmd_t  cmd,
  input  logic [7:0]        in_byte,
  output sha1sh_pkg::sts_t  sts,
  output logic [31:0]       digest_word
);

  logic [511:0] buf_r;        // oldest byte in the top bits; word 0 = w[r]
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  chain_r [5];
  logic [63:0]  count_r;
  logic [63:0]  saved_r;

  logic [7:0]   push_byte;
  logic [63:0]  len_shifted;
  logic [5:0]   len_shift;
  logic [31:0]  w0, w2, w8, w13, w_new_x, w_new;
  logic [31:0]  f_val, k_val, t_val;

  assign sts.fill_pos = count_r[8:3];

  assign len_shift   = {3'd7 - count_r[5:3], 3'b000};
  assign len_shifted = saved_r >> len_shift;

  always_comb begin
    case (cmd.bsel)
      sha1sh_pkg::BSEL_DATA:  push_byte = in_byte;
      sha1sh_pkg::BSEL_PAD80: push_byte = 8'h80;
      sha1sh_pkg::BSEL_ZERO:  push_byte = 8'h00;
      sha1sh_pkg::BSEL_LEN:   push_byte = len_shifted[7:0];
      default:                push_byte = 8'h00;
    endcase
  end

  assign w0      = buf_r[511:480];
  assign w2      = buf_r[447:416];
  assign w8      = buf_r[255:224];
  assign w13     = buf_r[95:64];
  assign w_new_x = w13 ^ w8 ^ w2 ^ w0;
  assign w_new   = {w_new_x[30:0], w_new_x[31]};

  always_comb begin
    case (cmd.phase)
      sha1sh_pkg::PH_CH: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = sha1sh_pkg::K_CH;
      end
      sha1sh_pkg::PH_PAR0: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1sh_pkg::K_PAR0;
      end
      sha1sh_pkg::PH_MAJ: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = sha1sh_pkg::K_MAJ;
      end
      sha1sh_pkg::PH_PAR1: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1sh_pkg::K_PAR1;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = sha1sh_pkg::K_PAR1;
      end
    endcase
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w0;

  // Buffer doubles as the rolling schedule window during rounds
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      buf_r <= {buf_r[503:0], push_byte};
    end else if (cmd.round_en) begin
      buf_r <= {buf_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_len) begin
      saved_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_msg) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= sha1sh_pkg::INIT_CHAIN[159 - 32*i -: 32];
      end
      count_r <= 64'd0;
    end else begin
      if (cmd.final_add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.push) begin
        count_r <= count_r + 64'd8;
      end
    end
  end

  always_comb begin
    case (cmd.word_sel)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[0];
    endcase
  end

endmodule

// ===== design/sha1sh_ctrl.sv =====
// SHA-1 controller: byte intake, padding sequence, round count, digest output.
// Uses sha1sh_pkg and the assertion macros in sha1_stream_hasher_top_defines.svh.
`include "sha1_stream_hasher_top_defines.svh"

module sha1sh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_kind,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [2:0]        out_word_index,
  output logic              out_last,
  input  sha1sh_pkg::sts_t  sts,
  output sha1sh_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_FINAL = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] wi_r, wi_nxt;
  logic       first_r, first_nxt;   // next pad byte is the 0x80 marker
  logic       lenph_r, lenph_nxt;   // emitting the length bytes
  logic       pad_r, pad_nxt;       // finish in progress
  logic       block_full;
  logic       rnd_last;
  logic       digest_done;
  logic       msg_cleared;

  assign block_full     = (sts.fill_pos == sha1sh_pkg::FILL_LAST_POS);
  assign out_word_index = wi_r;
  assign out_last       = (wi_r == sha1sh_pkg::LAST_WORD_IDX);

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    wi_nxt     = wi_r;
    first_nxt  = first_r;
    lenph_nxt  = lenph_r;
    pad_nxt    = pad_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    cmd.bsel   = sha1sh_pkg::BSEL_DATA;
    cmd.word_sel = wi_r;
    if (rnd_r < 7'd20) begin
      cmd.phase = sha1sh_pkg::PH_CH;
    end else if (rnd_r < 7'd40) begin
      cmd.phase = sha1sh_pkg::PH_PAR0;
    end else if (rnd_r < 7'd60) begin
      cmd.phase = sha1sh_pkg::PH_MAJ;
    end else begin
      cmd.phase = sha1sh_pkg::PH_PAR1;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind) begin
            cmd.capture_len = 1'b1;
            first_nxt       = 1'b1;
            lenph_nxt       = 1'b0;
            pad_nxt         = 1'b1;
            state_nxt       = S_PAD;
          end else begin
            cmd.push = 1'b1;
            if (block_full) begin
              cmd.load_work = 1'b1;
              rnd_nxt       = 7'd0;
              state_nxt     = S_ROUND;
            end
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (first_r) begin
          cmd.bsel  = sha1sh_pkg::BSEL_PAD80;
          first_nxt = 1'b0;
        end else if (lenph_r || (sts.fill_pos == sha1sh_pkg::FILL_LEN_POS)) begin
          cmd.bsel  = sha1sh_pkg::BSEL_LEN;
          lenph_nxt = 1'b1;
        end else begin
          cmd.bsel  = sha1sh_pkg::BSEL_ZERO;
        end
        if (block_full) begin
          cmd.load_work = 1'b1;
          rnd_nxt       = 7'd0;
          state_nxt     = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 7'd1;
        if (rnd_r == sha1sh_pkg::LAST_RND) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        if (!pad_r) begin
          state_nxt = S_IDLE;
        end else if (lenph_r) begin
          // length field only ever ends a block, so the message is done
          wi_nxt    = 3'd0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (wi_r == sha1sh_pkg::LAST_WORD_IDX) begin
            cmd.clear_msg = 1'b1;
            pad_nxt       = 1'b0;
            lenph_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            wi_nxt = wi_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= 7'd0;
      wi_r    <= 3'd0;
      first_r <= 1'b0;
      lenph_r <= 1'b0;
      pad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      wi_r    <= wi_nxt;
      first_r <= first_nxt;
      lenph_r <= lenph_nxt;
      pad_r   <= pad_nxt;
    end
  end

  assign rnd_last    = (state_r == S_ROUND) && (rnd_r == sha1sh_pkg::LAST_RND);
  assign digest_done = out_tvalid && out_tready && out_last;
  assign msg_cleared = (state_r == S_IDLE) && (sts.fill_pos == 6'd0);

  `SHA1SH_ASSERT_IMP(a_no_overlap, in_tready, !out_tvalid, "input and output open together")
  `SHA1SH_ASSERT_NXT(a_round_end, rnd_last, state_r == S_FINAL, "no final add after last round")
  `SHA1SH_ASSERT_NXT(a_emit_done, digest_done, msg_cleared, "message state not cleared after digest")

endmodule

// ===== sim/sha1_digest_checker.sv =====
// Transfer monitor and SHA-1 predictor for the stream hasher testbench.
// Watches the in_ and out_ channels and compares each digest word with its prediction.
// Self-contained; instantiated by sha1_stream_hasher_top_test.
`timescale 1ns / 100ps

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          outstanding
);

  localparam logic [31:0] RK_CH   = 32'h5A827999;
  localparam logic [31:0] RK_PAR0 = 32'h6ED9EBA1;
  localparam logic [31:0] RK_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] RK_PAR1 = 32'hCA62C1D6;
  localparam logic [31:0] IV_WORDS [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                           32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0]  PAD_LEAD    = 8'h80;
  localparam logic [7:0]  PAD_FILL    = 8'h00;
  localparam logic [5:0]  LEN_FIELD   = 6'd56;
  localparam logic [5:0]  BLOCK_END   = 6'd63;
  localparam int          DIGEST_LEN  = 5;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic [31:0] hash_h  [5];
  logic [7:0]  blk_buf [64];
  logic [63:0] msg_bits;
  digest_exp_t digest_q [$];

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++) begin
      w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    end
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        t = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
        w[r%16] = {t[30:0], t[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK_PAR0;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = RK_PAR1;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r%16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  function automatic void absorb_byte(logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    blk_buf[pos] = v;
    msg_bits += 64'd8;
    if (pos == BLOCK_END) compress_block();
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < DIGEST_LEN; i++) hash_h[i] = IV_WORDS[i];
    msg_bits = '0;
  endfunction

  // pad, append the length as it stood before padding, queue the digest, restart the message
  function automatic void finish_message();
    logic [63:0] saved;
    digest_exp_t d;
    saved = msg_bits;
    absorb_byte(PAD_LEAD);
    while (msg_bits[8:3] != LEN_FIELD) absorb_byte(PAD_FILL);
    for (int i = 0; i < 8; i++) absorb_byte(saved[63-8*i -: 8]);
    for (int i = 0; i < DIGEST_LEN; i++) begin
      d.word = hash_h[i];
      d.idx  = 3'(i);
      d.last = (i == DIGEST_LEN - 1);
      digest_q.push_back(d);
    end
    restart_message();
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: digest mismatch on %s: got %h, expected %h", $time, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : watch
    digest_exp_t want;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser) finish_message();
        else absorb_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected transfer", {24'b0, out_tdata}, '0);
        end else begin
          want = digest_q.pop_front();
          if (out_tdata[31:0] !== want.word)
            report_mismatch("digest_word", 64'(out_tdata[31:0]), 64'(want.word));
          if (out_tdata[34:32] !== want.idx)
            report_mismatch("word_index", 64'(out_tdata[34:32]), 64'(want.idx));
          if (out_tlast !== want.last)
            report_mismatch("last_word", 64'(out_tlast), 64'(want.last));
          if (out_tdata[39:35] !== '0)
            report_mismatch("tdata padding", 64'(out_tdata[39:35]), '0);
        end
      end
      outstanding <= digest_q.size();
    end
  end

endmodule

// ===== sim/sha1_stream_hasher_top_test.sv =====
// Top of the SHA-1 stream hasher testbench: clock, reset, stimulus and verdict.
// Depends on sha1_stream_hasher_top and sha1_digest_checker.
`timescale 1ns / 100ps

module sha1_stream_hasher_top_test;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;
  localparam int   RAND_ITEMS  = 190;
  localparam int   MIN_MSGS    = 4;
  localparam int   HOLD_CYCLES = 400;
  localparam int   DRAIN_CYCLES = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        hold_req   = 1'b0;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;

  // message lengths around the one- and two-block padding boundaries
  int edge_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  sha1_stream_hasher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sha1_digest_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom_range(255)));
    send_item(KIND_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct  = 85;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 85;
      end
      default: begin
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
      end
    endcase
  endtask

  initial begin
    int msgs;
    int len;
    int base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty messages back to back, then short known messages and byte extremes
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_FINISH, 8'hFF);
    send_item(KIND_DATA, 8'h61);
    send_item(KIND_DATA, 8'h62);
    send_item(KIND_DATA, 8'h63);
    send_item(KIND_FINISH, 8'h5A);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_FINISH, 8'hA5);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_FINISH, 8'h00);

    // long output hold-off: the first digest backs up and the input stalls
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_message(3);
    send_message(2);

    base = items_sent;
    msgs = 0;
    while (items_sent - base < RAND_ITEMS || msgs < MIN_MSGS) begin
      set_idling(((items_sent - base) * 4 / RAND_ITEMS > 3) ? 3
                 : (items_sent - base) * 4 / RAND_ITEMS);
      case ($urandom_range(3))
        0, 1: len = $urandom_range(8);
        2:    len = edge_lens[$urandom_range(7)];
        default: len = $urandom_range(70, 1);
      endcase
      send_message(len);
      msgs++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("sha1_stream_hasher_top_test passed");
    end else begin
      $display("sha1_stream_hasher_top_test failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("sha1_stream_hasher_top_test failed");
    $finish;
  end

endmodule
